// ===== hdl/ipv4_icmp_header_checker_assert.svh =====
// Assertion macros for the checker module.
`ifndef IPV4_ICMP_HEADER_CHECKER_ASSERT_SVH
`define IPV4_ICMP_HEADER_CHECKER_ASSERT_SVH

// Same-cycle implication, held off during reset.
`define IICC_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("iicc assertion failed");

// Next-cycle implication, held off during reset.
`define IICC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("iicc assertion failed");

`endif

// ===== hdl/iicc_pkg.sv =====
`default_nettype none

package iicc_pkg;

  localparam int unsigned HEADER_BYTES = 20;
  localparam int unsigned FIFO_DEPTH   = 2;
  localparam int unsigned PTR_W        = $clog2(FIFO_DEPTH);

  localparam logic [3:0] IP_VERSION_4      = 4'd4;
  localparam logic [3:0] MIN_IHL           = 4'd5;
  localparam logic [7:0] PROTO_ICMP        = 8'd1;
  localparam logic [7:0] ICMP_UNREACHABLE  = 8'd3;
  localparam logic [7:0] ICMP_ECHO_REQUEST = 8'd8;
  localparam logic [15:0] SUM_GOOD         = 16'hffff;
  localparam logic [15:0] COUNT_MAX        = 16'hffff;

  // Byte offsets inside the fixed header.
  localparam logic [15:0] OFS_VER_IHL = 16'd0;
  localparam logic [15:0] OFS_TOS     = 16'd1;
  localparam logic [15:0] OFS_TTL     = 16'd8;
  localparam logic [15:0] OFS_PROTO   = 16'd9;
  localparam logic [15:0] OFS_SRC     = 16'd12;
  localparam logic [15:0] OFS_DST     = 16'd16;
  localparam logic [15:0] OFS_HDR_END = 16'(HEADER_BYTES);

  // Verdict codes.
  localparam logic [3:0] VERDICT_OK          = 4'd0;
  localparam logic [3:0] VERDICT_BAD_VERSION = 4'd1;
  localparam logic [3:0] VERDICT_SHORT_IHL   = 4'd2;
  localparam logic [3:0] VERDICT_TTL_ZERO    = 4'd3;
  localparam logic [3:0] VERDICT_BAD_SUM     = 4'd4;
  localparam logic [3:0] VERDICT_NOT_ICMP    = 4'd5;
  localparam logic [3:0] VERDICT_UNREACH     = 4'd6;
  localparam logic [3:0] VERDICT_OTHER_TYPE  = 4'd7;
  localparam logic [3:0] VERDICT_TRUNCATED   = 4'd8;

  // One finished packet, handed from front to back.
  typedef struct packed {
    logic [7:0]  version_ihl;
    logic [7:0]  tos;
    logic [7:0]  ttl;
    logic [7:0]  protocol;
    logic [7:0]  icmp_type;
    logic [15:0] sum;
    logic        pad_high;
    logic [7:0]  high_byte;
    logic [31:0] source;
    logic [31:0] dest;
    logic [15:0] count;
  } rec_t;

  // Ones' complement add with end-around carry.
  function automatic logic [15:0] fold_add(input logic [15:0] acc, input logic [15:0] word);
    logic [16:0] s;
    s = {1'b0, acc} + {1'b0, word};
    return s[15:0] + {15'd0, s[16]};
  endfunction

endpackage

`default_nettype wire

// ===== hdl/iicc_byte_if.sv =====
`default_nettype none

interface iicc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

`default_nettype wire

// ===== hdl/iicc_verdict_if.sv =====
`default_nettype none

interface iicc_verdict_if;
  logic        valid;
  logic        ready;
  logic [3:0]  verdict;
  logic [7:0]  service_type;
  logic [31:0] source_address;
  logic [31:0] dest_address;
  logic [15:0] packet_bytes;

  modport source (output valid, output verdict, output service_type,
                  output source_address, output dest_address, output packet_bytes,
                  input ready);
  modport sink (input valid, input verdict, input service_type,
                input source_address, input dest_address, input packet_bytes,
                output ready);
endinterface

`default_nettype wire

// ===== hdl/iicc_front.sv =====
`default_nettype none

module iicc_front (
  input  wire logic         clk,
  input  wire logic         rst,
  iicc_byte_if.sink         rx,
  input  wire logic         full,
  output logic              push,
  output iicc_pkg::rec_t    rec
);

  logic [15:0] byte_position;
  logic [15:0] sum_acc;
  logic [7:0]  high_hold;
  logic [7:0]  ver_ihl;
  logic [7:0]  tos_hold;
  logic [7:0]  ttl_hold;
  logic [7:0]  proto_hold;
  logic [31:0] src_hold;
  logic [31:0] dst_hold;
  logic [7:0]  icmp_hold;

  logic [15:0] sum_next;
  logic [7:0]  high_next;
  logic [7:0]  ver_ihl_next;
  logic [7:0]  tos_next;
  logic [7:0]  ttl_next;
  logic [7:0]  proto_next;
  logic [31:0] src_next;
  logic [31:0] dst_next;
  logic [7:0]  icmp_next;
  logic [15:0] count_next;
  logic        in_hdr;
  logic        accept;

  assign rx.ready = !full;
  assign accept   = rx.valid && rx.ready;
  assign in_hdr   = byte_position < iicc_pkg::OFS_HDR_END;

  always_comb begin
    high_next    = (in_hdr && !byte_position[0]) ? rx.data_byte : high_hold;
    sum_next     = (in_hdr && byte_position[0])
                   ? iicc_pkg::fold_add(sum_acc, {high_hold, rx.data_byte}) : sum_acc;
    ver_ihl_next = (byte_position == iicc_pkg::OFS_VER_IHL) ? rx.data_byte : ver_ihl;
    tos_next     = (byte_position == iicc_pkg::OFS_TOS) ? rx.data_byte : tos_hold;
    ttl_next     = (byte_position == iicc_pkg::OFS_TTL) ? rx.data_byte : ttl_hold;
    proto_next   = (byte_position == iicc_pkg::OFS_PROTO) ? rx.data_byte : proto_hold;
    src_next     = (byte_position >= iicc_pkg::OFS_SRC && byte_position < iicc_pkg::OFS_DST)
                   ? {src_hold[23:0], rx.data_byte} : src_hold;
    dst_next     = (byte_position >= iicc_pkg::OFS_DST && in_hdr)
                   ? {dst_hold[23:0], rx.data_byte} : dst_hold;
    icmp_next    = (byte_position == iicc_pkg::OFS_HDR_END) ? rx.data_byte : icmp_hold;
    count_next   = (byte_position == iicc_pkg::COUNT_MAX) ? byte_position
                                                          : byte_position + 16'd1;
  end

  always_comb begin
    push          = accept && rx.last_byte;
    rec.version_ihl = ver_ihl_next;
    rec.tos       = tos_next;
    rec.ttl       = ttl_next;
    rec.protocol  = proto_next;
    rec.icmp_type = icmp_next;
    rec.sum       = sum_next;
    // odd-length short header: last high byte still needs its word added
    rec.pad_high  = (count_next < iicc_pkg::OFS_HDR_END) && count_next[0];
    rec.high_byte = high_next;
    rec.source    = src_next;
    rec.dest      = dst_next;
    rec.count     = count_next;
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && rx.last_byte)) begin
      byte_position <= '0;
      sum_acc       <= '0;
      high_hold     <= '0;
      ver_ihl       <= '0;
      tos_hold      <= '0;
      ttl_hold      <= '0;
      proto_hold    <= '0;
      src_hold      <= '0;
      dst_hold      <= '0;
      icmp_hold     <= '0;
    end else if (accept) begin
      byte_position <= count_next;
      sum_acc       <= sum_next;
      high_hold     <= high_next;
      ver_ihl       <= ver_ihl_next;
      tos_hold      <= tos_next;
      ttl_hold      <= ttl_next;
      proto_hold    <= proto_next;
      src_hold      <= src_next;
      dst_hold      <= dst_next;
      icmp_hold     <= icmp_next;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/iicc_fifo.sv =====
`default_nettype none

module iicc_fifo (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire iicc_pkg::rec_t  push_rec,
  output logic                 full,
  output logic                 not_empty,
  input  wire logic            pop,
  output iicc_pkg::rec_t       pop_rec
);

  iicc_pkg::rec_t                mem [iicc_pkg::FIFO_DEPTH];
  logic [iicc_pkg::PTR_W-1:0]    wr_ptr;
  logic [iicc_pkg::PTR_W-1:0]    rd_ptr;
  logic [iicc_pkg::PTR_W:0]      fill;
  logic                          do_push;
  logic                          do_pop;

  assign full      = fill == (iicc_pkg::PTR_W + 1)'(iicc_pkg::FIFO_DEPTH);
  assign not_empty = fill != '0;
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_rec   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == iicc_pkg::PTR_W'(iicc_pkg::FIFO_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == iicc_pkg::PTR_W'(iicc_pkg::FIFO_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      fill <= fill + {{iicc_pkg::PTR_W{1'b0}}, do_push} - {{iicc_pkg::PTR_W{1'b0}}, do_pop};
    end
  end

endmodule

`default_nettype wire

// ===== hdl/iicc_back.sv =====
`default_nettype none

module iicc_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            not_empty,
  input  wire iicc_pkg::rec_t  rec,
  output logic                 pop,
  iicc_verdict_if.source       tx
);

  logic [15:0] sum_final;
  logic [3:0]  verdict_next;

  assign pop = not_empty && (!tx.valid || tx.ready);

  always_comb begin
    sum_final = rec.pad_high ? iicc_pkg::fold_add(rec.sum, {rec.high_byte, 8'h00}) : rec.sum;
    if (rec.version_ihl[7:4] != iicc_pkg::IP_VERSION_4) begin
      verdict_next = iicc_pkg::VERDICT_BAD_VERSION;
    end else if (rec.version_ihl[3:0] < iicc_pkg::MIN_IHL) begin
      verdict_next = iicc_pkg::VERDICT_SHORT_IHL;
    end else if (rec.ttl == 8'd0) begin
      verdict_next = iicc_pkg::VERDICT_TTL_ZERO;
    end else if (sum_final != iicc_pkg::SUM_GOOD) begin
      verdict_next = iicc_pkg::VERDICT_BAD_SUM;
    end else if (rec.protocol != iicc_pkg::PROTO_ICMP) begin
      verdict_next = iicc_pkg::VERDICT_NOT_ICMP;
    end else if (rec.count <= iicc_pkg::OFS_HDR_END) begin
      verdict_next = iicc_pkg::VERDICT_TRUNCATED;
    end else if (rec.icmp_type == iicc_pkg::ICMP_UNREACHABLE) begin
      verdict_next = iicc_pkg::VERDICT_UNREACH;
    end else if (rec.icmp_type != iicc_pkg::ICMP_ECHO_REQUEST) begin
      verdict_next = iicc_pkg::VERDICT_OTHER_TYPE;
    end else begin
      verdict_next = iicc_pkg::VERDICT_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tx.valid <= 1'b0;
    end else if (pop) begin
      tx.valid <= 1'b1;
    end else if (tx.ready) begin
      tx.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      tx.verdict        <= verdict_next;
      tx.service_type   <= rec.tos;
      tx.source_address <= rec.source;
      tx.dest_address   <= rec.dest;
      tx.packet_bytes   <= rec.count;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/ipv4_icmp_header_checker.sv =====
// IPv4 header checker with ICMP echo-request screening.
//
// rx: one packet byte per beat (data_byte), last_byte marks the packet's
//   final beat. Bytes start at the first IPv4 header byte.
// tx: one verdict beat per packet, with TOS, source and destination address
//   and the byte count (saturating at 65535).
// Throughput: one byte per cycle, sustained; rx.ready drops only when the
//   two-entry packet queue is full.
// Output: the queue entry written when the last byte is taken is popped into
//   the verdict register, which raises tx.valid; a stalled tx delays the pop.
// Reset (rst, synchronous): clears the parse state, the queue and tx.valid.
// A stalled tx holds its beat; the back end stops popping, the queue fills,
//   and only then is rx stalled. Parsing itself never waits on tx.
`default_nettype none

module ipv4_icmp_header_checker (
  input  wire logic       clk,
  input  wire logic       rst,
  iicc_byte_if.sink       rx,
  iicc_verdict_if.source  tx
);

  // front end -> queue
  logic           push;
  iicc_pkg::rec_t push_rec;
  logic           full;

  // queue -> back end
  logic           not_empty;
  logic           pop;
  iicc_pkg::rec_t pop_rec;

  // Byte parser: field capture and running ones' complement sum.
  iicc_front u_front (
    .clk  (clk),
    .rst  (rst),
    .rx   (rx),
    .full (full),
    .push (push),
    .rec  (push_rec)
  );

  // Decouples parsing from a stalled output.
  iicc_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_rec  (push_rec),
    .full      (full),
    .not_empty (not_empty),
    .pop       (pop),
    .pop_rec   (pop_rec)
  );

  // Verdict priority chain and output register.
  iicc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .not_empty (not_empty),
    .rec       (pop_rec),
    .pop       (pop),
    .tx        (tx)
  );

endmodule

`default_nettype wire

// ===== hdl/iicc_checker.sv =====
`default_nettype none

`include "ipv4_icmp_header_checker_assert.svh"

module iicc_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [3:0]  verdict,
  input wire logic [15:0] packet_bytes
);

  `IICC_ASSERT_NEXT(a_hold_valid, clk, rst, out_valid && !out_ready, out_valid)
  `IICC_ASSERT_NEXT(a_hold_verdict, clk, rst, out_valid && !out_ready, $stable(verdict))
  `IICC_ASSERT_NOW(a_ok_has_type, clk, rst, out_valid && verdict == iicc_pkg::VERDICT_OK, packet_bytes > 16'd20)
  `IICC_ASSERT_NOW(a_trunc_short, clk, rst, out_valid && verdict == iicc_pkg::VERDICT_TRUNCATED, packet_bytes <= 16'd20)
  `IICC_ASSERT_NEXT(a_reset_idle, clk, 1'b0, rst, !out_valid)

endmodule

bind ipv4_icmp_header_checker iicc_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (tx.valid),
  .out_ready    (tx.ready),
  .verdict      (tx.verdict),
  .packet_bytes (tx.packet_bytes)
);

`default_nettype wire
